### sv/ppmd_pkg.sv
// Shared constants and types for the PPM frame decoder.
`timescale 1ns / 1ps

package ppmd_pkg;

    localparam int NUM_CHANNELS = 8;
    localparam int CH_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int TIME_W       = 32;
    localparam int GAP_W        = 16;
    localparam int CHAN_OUT_W   = 3;

    localparam int APB_ADDR_W   = 4;
    localparam int APB_DATA_W   = 32;

    localparam logic [GAP_W-1:0] SYNC_MIN_RST  = 16'd2200;
    localparam logic [GAP_W-1:0] PULSE_MIN_RST = 16'd900;
    localparam logic [GAP_W-1:0] PULSE_MAX_RST = 16'd2100;

    // register index = paddr[3:2]
    localparam logic [1:0] REG_SYNC_MIN  = 2'd0;
    localparam logic [1:0] REG_PULSE_MIN = 2'd1;
    localparam logic [1:0] REG_PULSE_MAX = 2'd2;

    typedef struct packed {
        logic [GAP_W-1:0] sync_min;
        logic [GAP_W-1:0] pulse_min;
        logic [GAP_W-1:0] pulse_max;
    } cfg_t;

    typedef logic [NUM_CHANNELS-1:0][GAP_W-1:0] frame_t;

endpackage

### sv/ppmd_regs.sv
// APB configuration registers of the PPM frame decoder.
`timescale 1ns / 1ps

module ppmd_regs
    import ppmd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_SYNC_MIN:  cfg_next.sync_min  = pwdata[GAP_W-1:0];
                REG_PULSE_MIN: cfg_next.pulse_min = pwdata[GAP_W-1:0];
                REG_PULSE_MAX: cfg_next.pulse_max = pwdata[GAP_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_SYNC_MIN:  prdata = APB_DATA_W'(cfg_reg.sync_min);
            REG_PULSE_MIN: prdata = APB_DATA_W'(cfg_reg.pulse_min);
            REG_PULSE_MAX: prdata = APB_DATA_W'(cfg_reg.pulse_max);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_min  <= SYNC_MIN_RST;
            cfg_reg.pulse_min <= PULSE_MIN_RST;
            cfg_reg.pulse_max <= PULSE_MAX_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### sv/ppmd_drain.sv
// Frame output buffer: holds a completed frame and shifts it out one word at a time.
`timescale 1ns / 1ps

module ppmd_drain
    import ppmd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  frame_t                frame,
    input  logic                  flag,
    output logic                  busy,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [CHAN_OUT_W-1:0] channel,
    output logic [GAP_W-1:0]      width,
    output logic                  sync_seen,
    output logic                  last
);

    frame_t          buf_reg;
    frame_t          buf_next;
    logic [CH_W-1:0] idx_reg;
    logic [CH_W-1:0] idx_next;
    logic            busy_reg;
    logic            busy_next;
    logic            flag_reg;
    logic            flag_next;
    logic            take;
    logic            at_last;

    assign take    = busy_reg & ~out_stall;
    assign at_last = (idx_reg == CH_W'(NUM_CHANNELS - 1));

    always_comb
    begin
        buf_next  = buf_reg;
        idx_next  = idx_reg;
        busy_next = busy_reg;
        flag_next = flag_reg;
        if (load)
        begin
            buf_next  = frame;
            idx_next  = '0;
            busy_next = 1'b1;
            flag_next = flag;
        end
        else if (take)
        begin
            // shift so the next word always sits in entry 0
            for (int k = 0; k < NUM_CHANNELS - 1; k++)
            begin
                buf_next[k] = buf_reg[k+1];
            end
            idx_next  = idx_reg + 1'b1;
            busy_next = ~at_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            busy_reg <= 1'b0;
            flag_reg <= 1'b0;
        end
        else
        begin
            idx_reg  <= idx_next;
            busy_reg <= busy_next;
            flag_reg <= flag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

    assign busy      = busy_reg;
    assign out_valid = busy_reg;
    assign channel   = CHAN_OUT_W'(idx_reg);
    assign width     = buf_reg[0];
    assign sync_seen = flag_reg;
    assign last      = at_last;

endmodule

### sv/ppm_frame_decoder.sv
// PPM frame decoder top level: gap measurement, sync tracking, channel store.
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+----------------------------------
//  input    | in        | in_valid / in_stall | edge_time
//  output   | out       | out_valid/out_stall | channel, width, sync_seen, last
//  config   | in        | APB, pready high    | sync_min, pulse_min, pulse_max
//
// An edge word is decoded in the cycle it is accepted; one edge per cycle
// while in_stall is low. A completed frame goes to the output buffer and
// leaves as one word per cycle while out_stall is low. in_stall rises only
// while the output buffer still holds a frame and the next edge could
// complete another; output stalls thus reach the input only then.
// After reset the block is unsynced with the registers at their defaults.
`timescale 1ns / 1ps

module ppm_frame_decoder
    import ppmd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [TIME_W-1:0]     edge_time,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [CHAN_OUT_W-1:0] channel,
    output logic [GAP_W-1:0]      width,
    output logic                  sync_seen,
    output logic                  last
);

    cfg_t            cfg;
    logic [TIME_W-1:0] prev_time_reg;
    logic            synced_reg;
    logic            synced_next;
    logic [CH_W-1:0] count_reg;
    logic [CH_W-1:0] count_next;
    logic            flag_reg;
    logic            flag_next;
    frame_t          chan_buf_reg;
    frame_t          frame;
    logic            accept;
    logic [GAP_W-1:0] gap;
    logic            is_sync;
    logic            in_win;
    logic            store;
    logic            count_full;
    logic            frame_done;
    logic            drain_busy;

    ppmd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign count_full = (count_reg == CH_W'(NUM_CHANNELS - 1));
    assign in_stall   = drain_busy & count_full;
    assign accept     = in_valid & ~in_stall;

    // modular difference, only the low bits survive
    assign gap     = edge_time[GAP_W-1:0] - prev_time_reg[GAP_W-1:0];
    assign is_sync = (gap >= cfg.sync_min);
    assign in_win  = (gap >= cfg.pulse_min) && (gap <= cfg.pulse_max);

    assign store      = accept & synced_reg & ~is_sync & in_win;
    assign frame_done = store & count_full;

    always_comb
    begin
        synced_next = synced_reg;
        count_next  = count_reg;
        flag_next   = flag_reg;
        if (accept)
        begin
            if (synced_reg)
            begin
                if (is_sync)
                begin
                    count_next = '0;
                    flag_next  = 1'b1;
                end
                else if (in_win)
                begin
                    count_next = count_full ? '0 : count_reg + 1'b1;
                end
                else
                begin
                    synced_next = 1'b0;
                end
            end
            else if (is_sync)
            begin
                synced_next = 1'b1;
                count_next  = '0;
                flag_next   = 1'b0;
            end
        end
    end

    // last channel goes straight from the gap, the rest from the store
    always_comb
    begin
        frame = chan_buf_reg;
        frame[NUM_CHANNELS-1] = gap;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_time_reg <= '0;
            synced_reg    <= 1'b0;
            count_reg     <= '0;
            flag_reg      <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                prev_time_reg <= edge_time;
            end
            synced_reg <= synced_next;
            count_reg  <= count_next;
            flag_reg   <= flag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store)
        begin
            chan_buf_reg[count_reg] <= gap;
        end
    end

    ppmd_drain u_drain (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (frame_done),
        .frame     (frame),
        .flag      (flag_reg),
        .busy      (drain_busy),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .channel   (channel),
        .width     (width),
        .sync_seen (sync_seen),
        .last      (last)
    );

    // a new frame must never land on one still being sent
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        frame_done |-> !drain_busy)
        else $error("frame completed while output buffer busy");

    // a completed frame starts with channel zero on the next cycle
    a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
        frame_done |=> (out_valid && channel == '0))
        else $error("frame did not start at channel zero");

    // a word with last marks the final channel
    a_last_chan: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last) |-> (channel == CHAN_OUT_W'(NUM_CHANNELS - 1)))
        else $error("last flag on wrong channel");

    // count only moves on an accepted edge
    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(count_reg))
        else $error("channel count changed without an edge");

endmodule
